// ----- hdl/cps_pkg.sv -----
// shared types and constants for the closest point on segment core
`default_nettype none
package cps_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned TW = 17;
  localparam int unsigned DiffW = 33;
  localparam int unsigned ProdW = 65;
  localparam int unsigned NumW = 67;
  localparam int unsigned DenW = 64;
  localparam int unsigned TFrac = 16;
  localparam logic [TW-1:0] TOne = 17'h10000;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [TW-1:0] tval_t;

  typedef struct packed {
    word_t dir_x;
    word_t dir_y;
    word_t dir_z;
    word_t start_x;
    word_t start_y;
    word_t start_z;
    word_t query_x;
    word_t query_y;
    word_t query_z;
  } cps_in_t;

  typedef struct packed {
    word_t near_x;
    word_t near_y;
    word_t near_z;
    tval_t param_t;
    logic  degenerate;
  } cps_out_t;

  // divider stage payload: direction, start, running remainder, divisor, quotient, degenerate flag
  typedef struct packed {
    word_t dir_x;
    word_t dir_y;
    word_t dir_z;
    word_t start_x;
    word_t start_y;
    word_t start_z;
    logic [DenW:0] rem;
    logic [DenW-1:0] den;
    tval_t t;
    logic  degenerate;
  } cps_div_t;
endpackage
`default_nettype wire

// ----- hdl/cps_stream_if.sv -----
// valid/ready channel carrying one packed payload
`default_nettype none
interface cps_stream_if #(parameter int unsigned Width = 8);
  logic valid;
  logic ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/cps_front.sv -----
// front end: differences, products, the two dot products and the clamp decision
`default_nettype none
module cps_front
  import cps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire cps_in_t  in_item,
  output logic          out_valid,
  output cps_div_t      out_item
);
  // stage 1: differences
  logic v1;
  cps_in_t a1;
  logic signed [DiffW-1:0] df [3];
  // stage 2: products
  logic v2;
  cps_in_t a2;
  logic signed [ProdW-1:0] pn [3];
  logic [DenW-1:0] pd [3];
  // stage 3: sums
  logic signed [NumW-1:0] num_s;
  logic [DenW+1:0] den_s;
  logic degen_s;
  tval_t t_next;
  logic [DenW:0] rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= in_item;
      df[0] <= DiffW'(in_item.query_x) - DiffW'(in_item.start_x);
      df[1] <= DiffW'(in_item.query_y) - DiffW'(in_item.start_y);
      df[2] <= DiffW'(in_item.query_z) - DiffW'(in_item.start_z);
      a2 <= a1;
      pn[0] <= ProdW'(df[0]) * ProdW'(a1.dir_x);
      pn[1] <= ProdW'(df[1]) * ProdW'(a1.dir_y);
      pn[2] <= ProdW'(df[2]) * ProdW'(a1.dir_z);
      pd[0] <= DenW'(ProdW'(a1.dir_x) * ProdW'(a1.dir_x));
      pd[1] <= DenW'(ProdW'(a1.dir_y) * ProdW'(a1.dir_y));
      pd[2] <= DenW'(ProdW'(a1.dir_z) * ProdW'(a1.dir_z));
    end
  end

  // clamp decided here; interior items start the divider with t = 0
  always_comb begin
    num_s = NumW'(pn[0]) + NumW'(pn[1]) + NumW'(pn[2]);
    den_s = (DenW+2)'(pd[0]) + (DenW+2)'(pd[1]) + (DenW+2)'(pd[2]);
    degen_s = (a2.dir_x == '0) && (a2.dir_y == '0) && (a2.dir_z == '0);
    t_next = '0;
    rem_next = '0;
    if (!degen_s && num_s > 0) begin
      if (NumW'(den_s) <= num_s) t_next = TOne;
      else rem_next = num_s[DenW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.dir_x <= a2.dir_x;
      out_item.dir_y <= a2.dir_y;
      out_item.dir_z <= a2.dir_z;
      out_item.start_x <= a2.start_x;
      out_item.start_y <= a2.start_y;
      out_item.start_z <= a2.start_z;
      out_item.den <= den_s[DenW-1:0];
      out_item.degenerate <= degen_s;
      out_item.rem <= rem_next;
      out_item.t <= t_next;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/cps_div_stage.sv -----
// one restoring division step per register stage
`default_nettype none
module cps_div_stage
  import cps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire cps_div_t in_item,
  output logic          out_valid,
  output cps_div_t      out_item
);
  logic [DenW:0] sh;
  logic ge;
  cps_div_t item_next;

  always_comb begin
    sh = {in_item.rem[DenW-1:0], 1'b0};
    ge = sh >= {1'b0, in_item.den};
    item_next = in_item;
    // clamped items carry rem = 0 and keep their t
    if (in_item.rem != '0) begin
      item_next.rem = ge ? sh - {1'b0, in_item.den} : sh;
      item_next.t = {in_item.t[TW-2:0], ge};
    end else if (in_item.t != TOne) begin
      item_next.t = {in_item.t[TW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) out_item <= item_next;
  end
endmodule
`default_nettype wire

// ----- hdl/cps_back.sv -----
// back end: scale direction by t, round, add start, saturate
`default_nettype none
module cps_back
  import cps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire cps_div_t in_item,
  output logic          out_valid,
  output cps_out_t      out_item
);
  localparam int unsigned MulW = WordW + TW + 1;
  localparam int unsigned SumW = WordW + 2;
  logic v1;
  cps_div_t a1;
  logic signed [MulW-1:0] pr [3];
  logic signed [SumW-1:0] sm [3];
  word_t nr [3];

  function automatic word_t sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32'sh7fffffff);
    lo = -SumW'(32'sh7fffffff) - SumW'(1);
    if (v > hi) return word_t'(hi);
    if (v < lo) return word_t'(lo);
    return word_t'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= in_item;
      pr[0] <= MulW'(in_item.dir_x) * $signed({1'b0, in_item.t});
      pr[1] <= MulW'(in_item.dir_y) * $signed({1'b0, in_item.t});
      pr[2] <= MulW'(in_item.dir_z) * $signed({1'b0, in_item.t});
    end
  end

  always_comb begin
    logic signed [MulW-1:0] rnd [3];
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (pr[i] + MulW'(32768)) >>> TFrac;
    end
    sm[0] = SumW'(a1.start_x) + SumW'(rnd[0]);
    sm[1] = SumW'(a1.start_y) + SumW'(rnd[1]);
    sm[2] = SumW'(a1.start_z) + SumW'(rnd[2]);
    for (int i = 0; i < 3; i++) nr[i] = sat(sm[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.near_x <= nr[0];
      out_item.near_y <= nr[1];
      out_item.near_z <= nr[2];
      out_item.param_t <= a1.t;
      out_item.degenerate <= a1.degenerate;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/closest_point_on_segment_core.sv -----
// Closest point on a 3D segment, Q16.16 in, Q16.16 point and Q1.16 t out.
// Channels: "in" carries direction, start and query per beat; "out" carries
// near_x/y/z, param_t and degenerate. One result per input beat, in order.
// Throughput: one beat per clock while out is not stalled. The pipeline has
// 21 register stages: three front stages (difference, multiply, dot sum and
// clamp), sixteen restoring division stages and two back stages (scale by t,
// then round/add/saturate into the output register).
// A zero direction gives near = start, param_t = 0, degenerate = 1.
// The whole pipeline advances as one; when out.ready is low and the output
// register is full, every stage holds and in.ready drops, so no beat is lost.
// Reset clears all valid bits; no state survives and none is needed.
`default_nettype none
module closest_point_on_segment_core
  import cps_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  cps_stream_if.sink in,
  cps_stream_if.source out
);
  localparam int unsigned Steps = TFrac;
  logic en;
  logic fv;
  cps_div_t fi;
  logic dv [Steps+1];
  cps_div_t di [Steps+1];
  logic bv;
  cps_out_t bi;

  assign en = !out.valid || out.ready;
  assign in.ready = en;

  cps_front u_front (.clk, .rst, .en, .in_valid(in.valid && en),
    .in_item(cps_in_t'(in.data)), .out_valid(fv), .out_item(fi));

  assign dv[0] = fv;
  assign di[0] = fi;
  for (genvar g = 0; g < Steps; g++) begin : g_div
    cps_div_stage u_stage (.clk, .rst, .en, .in_valid(dv[g]), .in_item(di[g]),
      .out_valid(dv[g+1]), .out_item(di[g+1]));
  end

  cps_back u_back (.clk, .rst, .en, .in_valid(dv[Steps]), .in_item(di[Steps]),
    .out_valid(bv), .out_item(bi));

  assign out.valid = bv;
  assign out.data = bi;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result changed while stalled");
  a_degen_t: assert property (@(posedge clk) disable iff (rst)
    out.valid && bi.degenerate |-> bi.param_t == '0)
    else $error("degenerate result with nonzero t");
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> bi.param_t <= TOne)
    else $error("t out of range");
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |-> !in.ready)
    else $error("input taken during stall");
endmodule
`default_nettype wire

// ----- bench/closest_point_on_segment_core_tb.sv -----
// testbench for the closest point on segment core: directed table, then random beats
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_segment_core_tb;
  import cps_pkg::*;

  localparam int unsigned InW = $bits(cps_in_t);
  localparam int unsigned OutW = $bits(cps_out_t);
  localparam int NumRandom = 1130;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 40;

  typedef struct {
    cps_in_t  query;
    logic     known;
    cps_out_t answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cps_stream_if #(.Width(InW)) in_ch ();
  cps_stream_if #(.Width(OutW)) out_ch ();

  closest_point_on_segment_core dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch)
  );

  always #5 clk = ~clk;

  cps_out_t pending_points[$];
  int mismatches = 0;
  int idle_cycles = 0;
  row_t table_rows[$];

  // exact closest point computation at full width
  function automatic cps_out_t nearest_point(cps_in_t a);
    cps_out_t r;
    logic signed [63:0] d[3], s[3], q[3];
    logic signed [127:0] num, p, sum;
    logic [127:0] den, rem;
    logic [16:0] t;
    d[0] = a.dir_x; d[1] = a.dir_y; d[2] = a.dir_z;
    s[0] = a.start_x; s[1] = a.start_y; s[2] = a.start_z;
    q[0] = a.query_x; q[1] = a.query_y; q[2] = a.query_z;
    num = 0;
    den = 0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      num += 128'(q[i] - s[i]) * 128'(d[i]);
      den += 128'(d[i] * d[i]);
    end
    r.degenerate = (den == 0);
    if (!r.degenerate && num > 0) begin
      if (num >= $signed(den)) begin
        t = TOne;
      end else begin
        rem = 128'(num) << TFrac;
        t = 17'(rem / den);
      end
    end
    for (int i = 0; i < 3; i++) begin
      p = 128'(d[i]) * $signed({111'd0, t});
      p = (p + 128'sd32768) >>> 16;
      sum = r.degenerate ? 128'(s[i]) : 128'(s[i]) + p;
      if (sum > 128'sd2147483647) sum = 128'sd2147483647;
      else if (sum < -128'sd2147483648) sum = -128'sd2147483648;
      case (i)
        0: r.near_x = sum[31:0];
        1: r.near_y = sum[31:0];
        default: r.near_z = sum[31:0];
      endcase
    end
    r.param_t = t;
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed(32'($urandom_range(0, 8)) - 4) <<< 16;
      4: return $signed(32'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cps_in_t rand_query();
    cps_in_t a;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    case ($urandom_range(0, 5))
      0: begin
        a.dir_x = rand_word(); a.dir_y = rand_word(); a.dir_z = rand_word();
        a.start_x = rand_word(); a.start_y = rand_word(); a.start_z = rand_word();
        a.query_x = rand_word(); a.query_y = rand_word(); a.query_z = rand_word();
      end
      1: begin
        // modest geometry so t lands inside the segment
        a.dir_x = $signed(a.dir_x) >>> 8; a.dir_y = $signed(a.dir_y) >>> 8;
        a.dir_z = $signed(a.dir_z) >>> 8;
        a.start_x = $signed(a.start_x) >>> 9; a.start_y = $signed(a.start_y) >>> 9;
        a.start_z = $signed(a.start_z) >>> 9;
        a.query_x = a.start_x + ($signed(a.dir_x) >>> 1) + ($signed(a.query_x) >>> 12);
        a.query_y = a.start_y + ($signed(a.dir_y) >>> 1) + ($signed(a.query_y) >>> 12);
        a.query_z = a.start_z + ($signed(a.dir_z) >>> 1) + ($signed(a.query_z) >>> 12);
      end
      2: begin
        a.dir_x = 0; a.dir_y = 0; a.dir_z = 0;
      end
      3: begin
        a.dir_x = $signed(a.dir_x) >>> $urandom_range(0, 31);
        a.dir_y = $signed(a.dir_y) >>> $urandom_range(0, 31);
        a.dir_z = $signed(a.dir_z) >>> $urandom_range(0, 31);
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic cps_in_t mk(word_t dx, word_t dy, word_t dz, word_t sx, word_t sy,
                                 word_t sz, word_t qx, word_t qy, word_t qz);
    return '{dx, dy, dz, sx, sy, sz, qx, qy, qz};
  endfunction

  task automatic add_row(cps_in_t a, logic known, cps_out_t r);
    row_t row;
    row.query = a;
    row.known = known;
    row.answer = r;
    table_rows.push_back(row);
  endtask

  task automatic send_beat(cps_in_t a, logic known, cps_out_t r);
    in_ch.valid <= 1'b1;
    in_ch.data <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_points.push_back(known ? r : nearest_point(a));
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver stall pattern: stretches of full rate and choppy stretches
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (rst) out_ch.ready <= 1'b0;
    else if (stall_phase < 120) out_ch.ready <= 1'b1;
    else if (stall_phase < 300) out_ch.ready <= ($urandom_range(0, 2) != 0);
    else out_ch.ready <= ($urandom_range(0, 4) == 0);
  end

  always @(posedge clk) begin
    cps_out_t got, want;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = pending_points.pop_front();
          if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
              got.near_z !== want.near_z || got.param_t !== want.param_t ||
              got.degenerate !== want.degenerate) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    cps_out_t none_r;
    none_r = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    // zero direction gives the start point back
    add_row(mk(0, 0, 0, 32'sh12345678, -5, 32'sh80000000, 1, 2, 3), 1'b1,
            '{32'sh12345678, -5, 32'sh80000000, 17'd0, 1'b1});
    add_row(mk(0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0), 1'b1,
            '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 17'd0, 1'b1});
    // clamp low: query behind start
    add_row(mk(32'h10000, 0, 0, 0, 0, 0, -32'sh10000, 0, 0), 1'b1,
            '{0, 0, 0, 17'd0, 1'b0});
    // clamp high: query past end
    add_row(mk(32'h10000, 0, 0, 0, 0, 0, 32'sh50000, 0, 0), 1'b1,
            '{32'sh10000, 0, 0, TOne, 1'b0});
    // exactly at the end
    add_row(mk(0, 32'h20000, 0, 0, 0, 0, 0, 32'h20000, 0), 1'b1,
            '{0, 32'h20000, 0, TOne, 1'b0});
    // midpoint
    add_row(mk(0, 0, 32'h20000, 0, 0, 0, 0, 0, 32'h10000), 1'b1,
            '{0, 0, 32'h10000, 17'h8000, 1'b0});
    // extreme coordinates at both ends of the word range
    add_row(mk(32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0), 0, none_r);
    add_row(mk(32'sh80000000, 0, 0, 32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0), 0, none_r);
    add_row(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000), 0, none_r);
    add_row(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff), 0, none_r);
    // smallest direction, then other rounding cases
    add_row(mk(1, 1, 1, 0, 0, 0, 1, 0, 0), 0, none_r);
    add_row(mk(-1, 3, -7, 5, 5, 5, 2, 9, -1), 0, none_r);
    add_row(mk(3, 0, 0, 0, 0, 0, 1, 0, 0), 0, none_r);
    add_row(mk(32'sh7fffffff, 32'sh80000000, 1, -1, 0, 1, 12345, -6789, 3), 0, none_r);
    add_row(mk(32'h30000, 32'h40000, 0, 32'sh10000, 32'sh10000, 0,
               32'sh20000, 32'sh30000, 32'sh7000), 0, none_r);
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (table_rows[i]) send_beat(table_rows[i].query, table_rows[i].known,
                                      table_rows[i].answer);
    in_ch.valid <= 1'b0;
    // hold off until the pipeline has drained
    while (pending_points.size() != 0) @(negedge clk);
    for (int n = 0; n < NumRandom; n++) begin
      send_beat(rand_query(), 1'b0, none_r);
      idle_gap();
    end
    in_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) $display("closest_point_on_segment_core_tb passed");
    else $display("closest_point_on_segment_core_tb failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("closest_point_on_segment_core_tb failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- closest_point_on_segment_core.f -----
hdl/cps_pkg.sv
hdl/cps_stream_if.sv
hdl/cps_front.sv
hdl/cps_div_stage.sv
hdl/cps_back.sv
hdl/closest_point_on_segment_core.sv
bench/closest_point_on_segment_core_tb.sv
